// ===== design/igsp_pkg.sv =====
// Package for the implicit-graph shortest-path engine.
// Widths, register indexes, controller commands and datapath status.
// No dependencies.
`default_nettype none

package igsp_pkg;

    localparam int NODE_W     = 20;  // node fields of a request
    localparam int COST_W     = 7;   // edge cost registers
    localparam int MOD_W      = 21;  // modulus register
    localparam int PCOST_W    = 27;  // path cost result
    localparam int DIST_W     = 28;  // internal distance
    localparam int INODE_W    = 21;  // internal node, covers any modulus
    localparam int KEY_W      = DIST_W + INODE_W;
    localparam int PROD_W     = 2 * INODE_W;
    localparam int MOD_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(MOD_STEPS);
    localparam int DSTORE_W   = DIST_W + 1;  // visited bit and distance

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MOD_W;

    localparam logic [CFG_IDX_W-1:0] REG_COST_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COST_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd2;

    localparam int MAX_NODES_DEF  = 1048576;
    localparam int HEAP_DEPTH_DEF = 2097152;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_CLEAR,
        OP_INIT,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_POP_LAST,
        OP_SD_STEP,
        OP_SD_C1,
        OP_SD_C2,
        OP_SD_MOVE,
        OP_PROC_RD,
        OP_PROC_CHK,
        OP_RLX_RD,
        OP_RLX_CHK,
        OP_SU_STEP,
        OP_SU_CMP,
        OP_MUL,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_RLX2_SET,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic same;
        logic clear_last;
        logic hc_zero;
        logic pop_last_one;
        logic sd_end;
        logic has_c2;
        logic sd_stop;
        logic hit;
        logic stale;
        logic relax_take;
        logic heap_full;
        logic su_root;
        logic su_stop;
        logic mod_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/igsp_query_if.sv =====
// Request channel of the shortest-path engine: start and target node.
// Uses igsp_pkg for field widths.
`default_nettype none

interface igsp_query_if;
    logic                          valid;
    logic                          ready;
    logic [igsp_pkg::NODE_W-1:0]   start_node;
    logic [igsp_pkg::NODE_W-1:0]   target_node;

    modport source (output valid, output start_node, output target_node, input ready);
    modport sink   (input valid, input start_node, input target_node, output ready);
endinterface

`default_nettype wire

// ===== design/igsp_result_if.sv =====
// Result channel of the shortest-path engine: path cost and bad flag.
// Uses igsp_pkg for field widths.
`default_nettype none

interface igsp_result_if;
    logic                          valid;
    logic                          ready;
    logic [igsp_pkg::PCOST_W-1:0]  path_cost;
    logic                          bad_query;

    modport source (output valid, output path_cost, output bad_query, input ready);
    modport sink   (input valid, input path_cost, input bad_query, output ready);
endinterface

`default_nettype wire

// ===== design/igsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module igsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== design/igsp_dp.sv =====
// Datapath of the shortest-path engine: config registers, distance store,
// heap store, heap index arithmetic and the serial remainder unit.
// Depends on igsp_pkg and igsp_ram.
`default_nettype none

module igsp_dp #(
    parameter int MAX_NODES  = igsp_pkg::MAX_NODES_DEF,
    parameter int HEAP_DEPTH = igsp_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [igsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [igsp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [igsp_pkg::NODE_W-1:0]        i_start_node,
    input  wire logic [igsp_pkg::NODE_W-1:0]        i_target_node,
    input  wire igsp_pkg::t_cmd                     i_cmd,
    output igsp_pkg::t_sts                          o_sts,
    output logic      [igsp_pkg::PCOST_W-1:0]       o_path_cost,
    output logic                                    o_bad_query
);
    import igsp_pkg::*;

    localparam int DAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int HAW = $clog2(HEAP_DEPTH);
    localparam int HCW = $clog2(HEAP_DEPTH + 1);
    localparam int CW  = HAW + 2;

    logic [COST_W-1:0]  r_cost_a, r_cost_b;
    logic [MOD_W-1:0]   r_modulus;
    logic [MOD_W-1:0]   m_eff;

    logic [NODE_W-1:0]  r_s, r_t;
    logic [MOD_W-1:0]   r_m, r_cnt;
    logic [HCW-1:0]     r_hc;
    logic [DIST_W-1:0]  r_d, r_nd;
    logic [INODE_W-1:0] r_z, r_node;
    logic [KEY_W-1:0]   r_last, r_cv, r_key;
    logic [HAW-1:0]     r_i, r_c;
    logic [PROD_W-1:0]  r_prod;
    logic [MOD_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_stepc;
    logic [PCOST_W-1:0] r_res;
    logic               r_resbad;

    logic [MOD_W-1:0]   n_cnt;
    logic [HCW-1:0]     n_hc;
    logic [DIST_W-1:0]  n_d, n_nd;
    logic [INODE_W-1:0] n_z, n_node;
    logic [KEY_W-1:0]   n_last, n_cv, n_key;
    logic [HAW-1:0]     n_i, n_c;
    logic [PROD_W-1:0]  n_prod;
    logic [MOD_W-1:0]   n_rem;
    logic [STEP_W-1:0]  n_stepc;
    logic [PCOST_W-1:0] n_res;
    logic               n_resbad;

    logic               d_we;
    logic [DAW-1:0]     d_waddr, d_raddr;
    logic [DSTORE_W-1:0] d_wdata, d_q;
    logic               h_we;
    logic [HAW-1:0]     h_waddr, h_raddr;
    logic [KEY_W-1:0]   h_wdata, h_q;

    logic [CW-1:0]      c_w;
    logic [MOD_W:0]     rem2;
    logic [INODE_W-1:0] z_inc;
    logic               q_vis;
    logic [DIST_W-1:0]  q_dist;

    igsp_ram #(.WIDTH(DSTORE_W), .DEPTH(MAX_NODES)) u_dist (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    igsp_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    assign q_vis  = d_q[DIST_W];
    assign q_dist = d_q[DIST_W-1:0];
    assign c_w    = {1'b0, r_i, 1'b1};
    assign rem2   = {r_rem, r_prod[PROD_W-1]};
    assign z_inc  = r_z + 1'b1;

    // saturate the node count to the store depth
    always_comb begin
        m_eff = r_modulus;
        if (32'(r_modulus) > MAX_NODES) begin
            m_eff = MOD_W'(MAX_NODES);
        end
    end

    always_comb begin
        o_sts.bad          = ({1'b0, r_s} >= r_m) || ({1'b0, r_t} >= r_m);
        o_sts.same         = (r_s == r_t);
        o_sts.clear_last   = (r_cnt == r_m - 1'b1);
        o_sts.hc_zero      = (r_hc == '0);
        o_sts.pop_last_one = (r_hc == HCW'(1));
        o_sts.sd_end       = (c_w >= CW'(r_hc));
        o_sts.has_c2       = ((CW'(r_c) + 1'b1) < CW'(r_hc));
        o_sts.sd_stop      = (r_cv >= r_last);
        o_sts.hit          = (r_z == INODE_W'(r_t));
        o_sts.stale        = (r_d > q_dist);
        o_sts.relax_take   = !q_vis || (r_nd < q_dist);
        o_sts.heap_full    = (32'(r_hc) >= HEAP_DEPTH);
        o_sts.su_root      = (r_i == '0);
        o_sts.su_stop      = (h_q <= r_key);
        o_sts.mod_last     = (r_stepc == STEP_W'(MOD_STEPS - 1));
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_hc     = r_hc;
        n_d      = r_d;
        n_nd     = r_nd;
        n_z      = r_z;
        n_node   = r_node;
        n_last   = r_last;
        n_cv     = r_cv;
        n_key    = r_key;
        n_i      = r_i;
        n_c      = r_c;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_stepc  = r_stepc;
        n_res    = r_res;
        n_resbad = r_resbad;
        d_we     = 1'b0;
        d_waddr  = DAW'(r_cnt);
        d_wdata  = '0;
        d_raddr  = DAW'(r_z);
        h_we     = 1'b0;
        h_waddr  = r_i;
        h_wdata  = r_last;
        h_raddr  = '0;

        case (i_cmd.op)
            OP_CHECK: begin
                n_res    = '0;
                n_resbad = o_sts.bad;
                n_cnt    = '0;
            end
            OP_CLEAR: begin
                d_we    = 1'b1;
                d_waddr = DAW'(r_cnt);
                n_cnt   = r_cnt + 1'b1;
            end
            OP_INIT: begin
                d_we    = 1'b1;
                d_waddr = DAW'(r_s);
                d_wdata = {1'b1, {DIST_W{1'b0}}};
                h_we    = 1'b1;
                h_waddr = '0;
                h_wdata = {{DIST_W{1'b0}}, INODE_W'(r_s)};
                n_hc    = HCW'(1);
            end
            OP_POP_RD: begin
                h_raddr = '0;
                if (o_sts.hc_zero) begin
                    n_res = '0;
                end
            end
            OP_POP_TAKE: begin
                n_d     = h_q[KEY_W-1:INODE_W];
                n_z     = h_q[INODE_W-1:0];
                n_hc    = r_hc - 1'b1;
                h_raddr = HAW'(r_hc - 1'b1);
                n_i     = '0;
            end
            OP_POP_LAST: begin
                n_last = h_q;
            end
            OP_SD_STEP: begin
                if (o_sts.sd_end) begin
                    h_we    = 1'b1;
                    h_waddr = r_i;
                    h_wdata = r_last;
                end else begin
                    n_c     = HAW'(c_w);
                    h_raddr = HAW'(c_w);
                end
            end
            OP_SD_C1: begin
                n_cv    = h_q;
                h_raddr = r_c + 1'b1;
            end
            OP_SD_C2: begin
                if (h_q < r_cv) begin
                    n_cv = h_q;
                    n_c  = r_c + 1'b1;
                end
            end
            OP_SD_MOVE: begin
                h_we    = 1'b1;
                h_waddr = r_i;
                if (o_sts.sd_stop) begin
                    h_wdata = r_last;
                end else begin
                    h_wdata = r_cv;
                    n_i     = r_c;
                end
            end
            OP_PROC_RD: begin
                d_raddr = DAW'(r_z);
                if (o_sts.hit) begin
                    n_res = PCOST_W'(r_d);
                end
            end
            OP_PROC_CHK: begin
                n_node = (z_inc == INODE_W'(r_m)) ? '0 : z_inc;
                n_nd   = r_d + DIST_W'(r_cost_a);
            end
            OP_RLX_RD: begin
                d_raddr = DAW'(r_node);
            end
            OP_RLX_CHK: begin
                if (o_sts.relax_take) begin
                    d_we    = 1'b1;
                    d_waddr = DAW'(r_node);
                    d_wdata = {1'b1, r_nd};
                    if (!o_sts.heap_full) begin
                        n_i   = HAW'(r_hc);
                        n_hc  = r_hc + 1'b1;
                        n_key = {r_nd, r_node};
                    end
                end
            end
            OP_SU_STEP: begin
                if (o_sts.su_root) begin
                    h_we    = 1'b1;
                    h_waddr = '0;
                    h_wdata = r_key;
                end else begin
                    n_c     = (r_i - 1'b1) >> 1;
                    h_raddr = (r_i - 1'b1) >> 1;
                end
            end
            OP_SU_CMP: begin
                h_we    = 1'b1;
                h_waddr = r_i;
                if (o_sts.su_stop) begin
                    h_wdata = r_key;
                end else begin
                    h_wdata = h_q;
                    n_i     = r_c;
                end
            end
            OP_MUL: begin
                n_prod = PROD_W'(r_z) * PROD_W'(r_z);
            end
            OP_MOD_INIT: begin
                n_prod  = r_prod + 1'b1;
                n_rem   = '0;
                n_stepc = '0;
            end
            OP_MOD_STEP: begin
                // restoring remainder, one dividend bit a cycle
                if (rem2 >= {1'b0, r_m}) begin
                    n_rem = MOD_W'(rem2 - {1'b0, r_m});
                end else begin
                    n_rem = MOD_W'(rem2);
                end
                n_prod  = r_prod << 1;
                n_stepc = r_stepc + 1'b1;
            end
            OP_RLX2_SET: begin
                n_node = INODE_W'(r_rem);
                n_nd   = r_d + DIST_W'(r_cost_b);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_a  <= '0;
            r_cost_b  <= '0;
            r_modulus <= MOD_W'(1);
            r_hc      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COST_A:  r_cost_a  <= i_cfg_data[COST_W-1:0];
                    REG_COST_B:  r_cost_b  <= i_cfg_data[COST_W-1:0];
                    REG_MODULUS: r_modulus <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_hc <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_s <= i_start_node;
            r_t <= i_target_node;
            r_m <= m_eff;
        end
        if (i_cmd.op == OP_FIN) begin
            o_path_cost <= r_res;
            o_bad_query <= r_resbad;
        end
        r_cnt    <= n_cnt;
        r_d      <= n_d;
        r_nd     <= n_nd;
        r_z      <= n_z;
        r_node   <= n_node;
        r_last   <= n_last;
        r_cv     <= n_cv;
        r_key    <= n_key;
        r_i      <= n_i;
        r_c      <= n_c;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_stepc  <= n_stepc;
        r_res    <= n_res;
        r_resbad <= n_resbad;
    end
endmodule

`default_nettype wire

// ===== design/igsp_ctrl.sv =====
// Controller of the shortest-path engine: sequences the clearing pass,
// heap pops and pushes, edge relaxation and the result handshake.
// Depends on igsp_pkg.
`default_nettype none

module igsp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire igsp_pkg::t_sts i_sts,
    output igsp_pkg::t_cmd      o_cmd
);
    import igsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_CLEAR, S_INIT, S_POP_RD, S_POP_TAKE, S_POP_LAST,
        S_SD_STEP, S_SD_C1, S_SD_C2, S_SD_MOVE, S_PROC_RD, S_PROC_CHK,
        S_RLX_RD, S_RLX_CHK, S_SU_STEP, S_SU_CMP, S_MUL, S_MOD_INIT,
        S_MOD_STEP, S_RLX2_SET, S_FIN
    } t_state;

    t_state r_state;
    logic   r_pass;    // set while the squared edge of the popped node is relaxed
    logic   fin_go;
    t_state after_relax;

    assign o_in_ready  = (r_state == S_IDLE);
    assign fin_go      = !o_out_valid || i_out_ready;
    assign after_relax = r_pass ? S_POP_RD : S_MUL;

    always_comb begin
        case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_CHECK:    o_cmd.op = OP_CHECK;
            S_CLEAR:    o_cmd.op = OP_CLEAR;
            S_INIT:     o_cmd.op = OP_INIT;
            S_POP_RD:   o_cmd.op = OP_POP_RD;
            S_POP_TAKE: o_cmd.op = OP_POP_TAKE;
            S_POP_LAST: o_cmd.op = OP_POP_LAST;
            S_SD_STEP:  o_cmd.op = OP_SD_STEP;
            S_SD_C1:    o_cmd.op = OP_SD_C1;
            S_SD_C2:    o_cmd.op = OP_SD_C2;
            S_SD_MOVE:  o_cmd.op = OP_SD_MOVE;
            S_PROC_RD:  o_cmd.op = OP_PROC_RD;
            S_PROC_CHK: o_cmd.op = OP_PROC_CHK;
            S_RLX_RD:   o_cmd.op = OP_RLX_RD;
            S_RLX_CHK:  o_cmd.op = OP_RLX_CHK;
            S_SU_STEP:  o_cmd.op = OP_SU_STEP;
            S_SU_CMP:   o_cmd.op = OP_SU_CMP;
            S_MUL:      o_cmd.op = OP_MUL;
            S_MOD_INIT: o_cmd.op = OP_MOD_INIT;
            S_MOD_STEP: o_cmd.op = OP_MOD_STEP;
            S_RLX2_SET: o_cmd.op = OP_RLX2_SET;
            S_FIN:      o_cmd.op = fin_go ? OP_FIN : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // in S_FIN the valid flag is set below instead
            if (o_out_valid && i_out_ready && (r_state != S_FIN)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= (i_sts.bad || i_sts.same) ? S_FIN : S_CLEAR;
                end
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT:     r_state <= S_POP_RD;
                S_POP_RD: begin
                    r_state <= i_sts.hc_zero ? S_FIN : S_POP_TAKE;
                end
                S_POP_TAKE: begin
                    r_state <= i_sts.pop_last_one ? S_PROC_RD : S_POP_LAST;
                end
                S_POP_LAST: r_state <= S_SD_STEP;
                S_SD_STEP: begin
                    r_state <= i_sts.sd_end ? S_PROC_RD : S_SD_C1;
                end
                S_SD_C1: begin
                    r_state <= i_sts.has_c2 ? S_SD_C2 : S_SD_MOVE;
                end
                S_SD_C2:    r_state <= S_SD_MOVE;
                S_SD_MOVE: begin
                    r_state <= i_sts.sd_stop ? S_PROC_RD : S_SD_STEP;
                end
                S_PROC_RD: begin
                    r_state <= i_sts.hit ? S_FIN : S_PROC_CHK;
                end
                S_PROC_CHK: begin
                    r_pass  <= 1'b0;
                    r_state <= i_sts.stale ? S_POP_RD : S_RLX_RD;
                end
                S_RLX_RD:   r_state <= S_RLX_CHK;
                S_RLX_CHK: begin
                    if (i_sts.relax_take && !i_sts.heap_full) begin
                        r_state <= S_SU_STEP;
                    end else begin
                        r_state <= after_relax;
                    end
                end
                S_SU_STEP: begin
                    r_state <= i_sts.su_root ? after_relax : S_SU_CMP;
                end
                S_SU_CMP: begin
                    r_state <= i_sts.su_stop ? after_relax : S_SU_STEP;
                end
                S_MUL:      r_state <= S_MOD_INIT;
                S_MOD_INIT: r_state <= S_MOD_STEP;
                S_MOD_STEP: begin
                    if (i_sts.mod_last) begin
                        r_state <= S_RLX2_SET;
                    end
                end
                S_RLX2_SET: begin
                    r_pass  <= 1'b1;
                    r_state <= S_RLX_RD;
                end
                S_FIN: begin
                    if (fin_go) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== design/implicit_graph_shortest_path.sv =====
// Shortest-path engine: Dijkstra with a binary min-heap over an implicit graph.
// A bad request or start equal to target goes straight to the result; otherwise
// a clearing pass over every node below the modulus, then per popped node a
// sift-down of the heap, a sift-up for each push and the serial remainder for
// the squared edge (z*z+1 mod m). One request at a time; results wait
// in an output register. Reset: costs 0, modulus 1, controller idle.
`default_nettype none

module implicit_graph_shortest_path #(
    parameter int MAX_NODES  = igsp_pkg::MAX_NODES_DEF,
    parameter int HEAP_DEPTH = igsp_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    igsp_query_if.sink                           i_query,
    igsp_result_if.source                        o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [igsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [igsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import igsp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    igsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_query.valid),
        .o_in_ready  (i_query.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    igsp_dp #(.MAX_NODES(MAX_NODES), .HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start_node  (i_query.start_node),
        .i_target_node (i_query.target_node),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_path_cost   (o_result.path_cost),
        .o_bad_query   (o_result.bad_query)
    );
endmodule

`default_nettype wire

// ===== tb/sv/implicit_graph_shortest_path_tb.sv =====
// Testbench for the implicit-graph shortest-path engine.
// Drives a directed table and then random requests, and checks every result against
// its typed answer or a local Dijkstra predictor. Depends on igsp_pkg and the channel interfaces.
`default_nettype none

module implicit_graph_shortest_path_tb;
    import igsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [NODE_W-1:0]     start_node;
        logic [NODE_W-1:0]     target_node;
        bit                    typed;
        logic [PCOST_W-1:0]    path_cost;
        logic                  bad_query;
    } t_row;

    typedef struct {
        logic [PCOST_W-1:0] path_cost;
        logic               bad_query;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    igsp_query_if  query_ch();
    igsp_result_if result_ch();

    implicit_graph_shortest_path dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_query    (query_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the registers
    logic [COST_W-1:0] cost_a_q  = '0;
    logic [COST_W-1:0] cost_b_q  = '0;
    logic [MOD_W-1:0]  modulus_q = 21'd1;

    t_answer pending_answers[$];
    int      fail_count = 0;
    bit      idle_on = 1'b1;
    bit      hold_req = 1'b0;
    int      quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        query_ch.valid       = 1'b0;
        query_ch.start_node  = '0;
        query_ch.target_node = '0;
        result_ch.ready      = 1'b0;
    end

    // Dijkstra over the implicit graph; tie order does not change the distance
    function automatic logic [PCOST_W-1:0] least_path_cost(int unsigned m, int unsigned s,
                                                           int unsigned t);
        longint unsigned frontier[$];
        bit              seen[];
        int unsigned     best_dist[];
        int              best_i;
        longint unsigned key;
        int unsigned     d, z, nxt, nd;
        longint unsigned zz;
        seen = new[m];
        best_dist = new[m];
        seen[s] = 1'b1;
        best_dist[s] = 0;
        frontier.insert(frontier.size(), {32'd0, s});
        while (frontier.size() > 0) begin
            best_i = 0;
            foreach (frontier[k])
                if (frontier[k] < frontier[best_i]) best_i = k;
            key = frontier[best_i];
            frontier.delete(best_i);
            d = key[63:32];
            z = key[31:0];
            if (z == t) return d[PCOST_W-1:0];
            if (d > best_dist[z]) continue;
            for (int e = 0; e < 2; e++) begin
                if (e == 0) begin
                    nxt = (z + 1) % m;
                    nd  = d + cost_a_q;
                end else begin
                    zz  = longint'(z) * longint'(z) + 1;
                    nxt = 32'(zz % m);
                    nd  = d + cost_b_q;
                end
                if (!seen[nxt] || nd < best_dist[nxt]) begin
                    seen[nxt] = 1'b1;
                    best_dist[nxt] = nd;
                    frontier.insert(frontier.size(), {nd, nxt});
                end
            end
        end
        return '0;
    endfunction

    function automatic t_answer predict_answer(logic [NODE_W-1:0] s, logic [NODE_W-1:0] t);
        t_answer     a;
        int unsigned m;
        m = modulus_q;
        if (m > MAX_NODES_DEF) m = MAX_NODES_DEF;
        a.path_cost = '0;
        a.bad_query = (s >= m) || (t >= m);
        if (!a.bad_query && s != t) a.path_cost = least_path_cost(m, s, t);
        return a;
    endfunction

    task automatic wait_drained();
        query_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_COST_A:  cost_a_q  = data[COST_W-1:0];
            REG_COST_B:  cost_b_q  = data[COST_W-1:0];
            REG_MODULUS: modulus_q = data[MOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_request(logic [NODE_W-1:0] s, logic [NODE_W-1:0] t, bit typed,
                                t_answer typed_answer);
        while (idle_on && $urandom_range(0, 99) < 38) begin
            query_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.start_node  <= s;
        query_ch.target_node <= t;
        do @(posedge i_clk); while (!query_ch.ready);
        pending_answers.insert(pending_answers.size(),
                               typed ? typed_answer : predict_answer(s, t));
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            result_ch.ready <= i_rst_n && (!idle_on || $urandom_range(0, 99) >= 38);
            @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result cost=%0d bad=%0b", $time,
                         result_ch.path_cost, result_ch.bad_query);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (result_ch.path_cost !== want.path_cost) begin
                    $display("%0t: path_cost expected %0d actual %0d", $time,
                             want.path_cost, result_ch.path_cost);
                    fail_count++;
                end
                if (result_ch.bad_query !== want.bad_query) begin
                    $display("%0t: bad_query expected %0b actual %0b", $time,
                             want.bad_query, result_ch.bad_query);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_row directed_rows[] = '{
        // after reset: modulus 1
        '{0, REG_COST_A, 0, 20'd0, 20'd0, 1, 27'd0, 1'b0},
        '{0, REG_COST_A, 0, 20'd0, 20'd1, 1, 27'd0, 1'b1},
        '{0, REG_COST_A, 0, 20'hFFFFF, 20'd0, 1, 27'd0, 1'b1},
        // modulus zero flags everything
        '{1, REG_MODULUS, 21'd0, 0, 0, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd0, 20'd0, 1, 27'd0, 1'b1},
        // modulus above the node count saturates
        '{1, REG_MODULUS, 21'h1FFFFF, 0, 0, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'hFFFFF, 20'hFFFFF, 1, 27'd0, 1'b0},
        '{0, REG_COST_A, 0, 20'h12345, 20'h12345, 1, 27'd0, 1'b0},
        '{1, REG_COST_A, 21'd100, 0, 0, 0, 0, 0},
        '{1, REG_COST_B, 21'd100, 0, 0, 0, 0, 0},
        '{1, REG_MODULUS, 21'd10, 0, 0, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd0, 20'd1, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd3, 20'd2, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd0, 20'd9, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd10, 20'd3, 1, 27'd0, 1'b1},
        '{0, REG_COST_A, 0, 20'd3, 20'd10, 1, 27'd0, 1'b1},
        '{1, REG_COST_A, 21'd0, 0, 0, 0, 0, 0},
        '{1, REG_COST_B, 21'd0, 0, 0, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd2, 20'd7, 1, 27'd0, 1'b0},
        // widest cost A field
        '{1, REG_COST_A, 21'd127, 0, 0, 0, 0, 0},
        '{1, REG_COST_B, 21'd1, 0, 0, 0, 0, 0},
        '{1, REG_MODULUS, 21'd16, 0, 0, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd15, 20'd14, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd5, 20'd4, 0, 0, 0},
        '{0, REG_COST_A, 0, 20'd1, 20'd0, 0, 0, 0}
    };

    initial begin
        t_answer     typed_answer;
        int unsigned m;
        int          pick;
        logic [NODE_W-1:0] s, t;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                typed_answer.path_cost = directed_rows[r].path_cost;
                typed_answer.bad_query = directed_rows[r].bad_query;
                send_request(directed_rows[r].start_node, directed_rows[r].target_node,
                             directed_rows[r].typed, typed_answer);
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_COST_A, $urandom_range(0, 127));
            write_reg(REG_COST_B, (phase == 1) ? 100 : $urandom_range(0, 127));
            write_reg(REG_MODULUS, (phase == 3) ? 1 : $urandom_range(2, 48));
            m = modulus_q;
            // hold the result side off while requests keep coming
            if (phase == 1) hold_req = 1'b1;
            idle_on = (phase != 2);
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(0, 99);
                s = $urandom_range(0, m - 1);
                t = $urandom_range(0, m - 1);
                if (pick < 10) t = s;
                else if (pick < 16) s = $urandom;
                else if (pick < 22) t = $urandom;
                send_request(s, t, 1'b0, typed_answer);
            end
        end
        idle_on = 1'b1;
        query_ch.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
